### rtl/core/ptsch_pkg.sv
// ----------------------------------------------------------------------------
// Periodic timer scheduler package
// Request and response types, operation and status codes, and cell controls.
// ----------------------------------------------------------------------------
package ptsch_pkg;

	localparam logic [2:0] OP_ADD    = 3'd0;
	localparam logic [2:0] OP_REMOVE = 3'd1;
	localparam logic [2:0] OP_PEEK   = 3'd2;
	localparam logic [2:0] OP_POP    = 3'd3;
	localparam logic [2:0] OP_POPDUE = 3'd4;

	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_EMPTY   = 2'd1;
	localparam logic [1:0] ST_FULL    = 2'd2;
	localparam logic [1:0] ST_PENDING = 2'd3;

	localparam int TIME_BITS   = 63;
	localparam int PERIOD_BITS = 32;

	typedef struct packed {
		logic [2:0]             op;
		logic                   clock_sel;
		logic [5:0]             timer_id;
		logic [TIME_BITS-1:0]   deadline;
		logic [PERIOD_BITS-1:0] period;
	} req_t;

	typedef struct packed {
		logic [1:0]           status;
		logic [5:0]           found_id;
		logic [TIME_BITS-1:0] fired_deadline;
		logic                 rearmed;
		logic [TIME_BITS-1:0] next_deadline;
	} rsp_t;

	typedef struct packed {
		logic add_we;
		logic clr;
		logic rearm;
		logic scan_en;
	} cell_ctl_t;

endpackage

### rtl/core/periodic_timer_scheduler.sv
// ----------------------------------------------------------------------------
// Periodic timer scheduler
// Timer store for several clocks as a row of cells with an earliest-timer scan.
// ----------------------------------------------------------------------------
// Add and remove: executed in S_EXEC, then the response strobe is registered.
// Peek and pops: S_SCAN, S_FIN and S_OUT in turn, the candidate walking the
// cell row one cell per cycle. One request at a time; busy is high meanwhile.
// Reset empties every slot and sets the sequence counter to one.
module periodic_timer_scheduler import ptsch_pkg::*; #(
	parameter int TIMER_SLOTS   = 64,
	parameter int SEQUENCE_BITS = 32,
	parameter int CLOCK_COUNT   = 2
) (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	input  req_t req,
	output logic busy,
	output logic done,
	output rsp_t rsp
);

	localparam int N  = TIMER_SLOTS;
	localparam int IW = $clog2(TIMER_SLOTS);
	localparam int SW = SEQUENCE_BITS;

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_EXEC = 3'd1;
	localparam logic [2:0] S_SCAN = 3'd2;
	localparam logic [2:0] S_FIN  = 3'd3;
	localparam logic [2:0] S_OUT  = 3'd4;

	logic [2:0]             state_q;
	logic [IW-1:0]          cnt_q;
	req_t                   req_q;
	rsp_t                   rsp_q;
	logic                   done_q;
	logic [SW-1:0]          seq_q;
	logic                   hit_q;
	logic [IW-1:0]          bid_q;
	logic [TIME_BITS-1:0]   bdl_q;
	logic                   brearm_q;
	logic [TIME_BITS-1:0]   nxt_q;

	cell_ctl_t              ctl [N];
	logic                   ch_valid [N+1];
	logic [IW-1:0]          ch_id [N+1];
	logic [TIME_BITS-1:0]   ch_dl [N+1];
	logic [PERIOD_BITS-1:0] ch_per [N+1];
	logic [SW-1:0]          ch_seq [N+1];
	logic [N-1:0]           pend;
	logic [N-1:0]           clk_of;
	logic [N-1:0]           id_hit;

	logic                   id_pending;
	logic                   id_on_clock;
	logic                   add_ok;
	logic                   add_bad;
	logic                   rem_ok;
	logic [TIME_BITS-1:0]   wr_dl;
	logic [63:0]            sum;
	logic                   due;

	assign ch_valid[0] = 1'b0;
	assign ch_id[0]    = '0;
	assign ch_dl[0]    = '0;
	assign ch_per[0]   = '0;
	assign ch_seq[0]   = '0;

	for (genvar k = 0; k < N; k++) begin : g_cell
		assign id_hit[k] = (32'(req_q.timer_id) == k);
		ptsch_cell #(.IW(IW), .SW(SW), .INDEX(k)) u_cell (
			.clk         (clk),
			.arst_n      (arst_n),
			.ctl         (ctl[k]),
			.wr_clock    (req_q.clock_sel),
			.wr_deadline (wr_dl),
			.wr_period   (req_q.period),
			.wr_seq      (seq_q),
			.sel_clock   (req_q.clock_sel),
			.in_valid    (ch_valid[k]),
			.in_id       (ch_id[k]),
			.in_deadline (ch_dl[k]),
			.in_period   (ch_per[k]),
			.in_seq      (ch_seq[k]),
			.out_valid   (ch_valid[k+1]),
			.out_id      (ch_id[k+1]),
			.out_deadline(ch_dl[k+1]),
			.out_period  (ch_per[k+1]),
			.out_seq     (ch_seq[k+1]),
			.pending     (pend[k]),
			.clock_of    (clk_of[k])
		);
	end

	assign id_pending  = |(id_hit & pend);
	assign id_on_clock = |(id_hit & pend & ~(clk_of ^ {N{req_q.clock_sel}}));
	assign add_bad     = (32'(req_q.timer_id) >= N) || (32'(req_q.clock_sel) >= CLOCK_COUNT);
	assign add_ok      = !add_bad && !id_pending;
	assign rem_ok      = id_on_clock;
	assign wr_dl       = (state_q == S_OUT) ? nxt_q : req_q.deadline;
	assign sum         = {1'b0, ch_dl[N]} + {32'b0, ch_per[N]};
	assign due         = (req_q.op != OP_POPDUE) || (ch_dl[N] <= req_q.deadline);

	always_comb begin
		for (int k = 0; k < N; k++) begin
			ctl[k].add_we  = (state_q == S_EXEC) && (req_q.op == OP_ADD) && add_ok && id_hit[k];
			ctl[k].clr     = ((state_q == S_EXEC) && (req_q.op == OP_REMOVE) && rem_ok
				&& id_hit[k]) || ((state_q == S_OUT) && hit_q && (req_q.op != OP_PEEK)
				&& !brearm_q && (bid_q == IW'(k)));
			ctl[k].rearm   = (state_q == S_OUT) && hit_q && (req_q.op != OP_PEEK)
				&& brearm_q && (bid_q == IW'(k));
			ctl[k].scan_en = (state_q == S_SCAN) && (cnt_q == IW'(k));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q   <= '0;
			done_q  <= 1'b0;
			seq_q   <= SW'(1);
		end else begin
			done_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (start) begin
						cnt_q <= '0;
						if (req.op inside {OP_PEEK, OP_POP, OP_POPDUE}) begin
							state_q <= S_SCAN;
						end else begin
							state_q <= S_EXEC;
						end
					end
				end
				S_EXEC: begin
					done_q  <= 1'b1;
					state_q <= S_IDLE;
					if ((req_q.op == OP_ADD) && add_ok) begin
						seq_q <= seq_q + SW'(1);
					end
				end
				S_SCAN: begin
					cnt_q <= cnt_q + IW'(1);
					if (cnt_q == IW'(N - 1)) begin
						state_q <= S_FIN;
					end
				end
				S_FIN: begin
					state_q <= S_OUT;
				end
				S_OUT: begin
					done_q  <= 1'b1;
					state_q <= S_IDLE;
					if (hit_q && (req_q.op != OP_PEEK) && brearm_q) begin
						seq_q <= seq_q + SW'(1);
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if ((state_q == S_IDLE) && start) begin
			req_q <= req;
		end
		if (state_q == S_FIN) begin
			hit_q    <= ch_valid[N] && due;
			bid_q    <= ch_id[N];
			bdl_q    <= ch_dl[N];
			brearm_q <= (ch_per[N] != '0);
			nxt_q    <= sum[63] ? {TIME_BITS{1'b1}} : sum[TIME_BITS-1:0];
		end
		if (state_q == S_EXEC) begin
			rsp_q <= '0;
			if (req_q.op == OP_ADD) begin
				rsp_q.status <= add_bad ? ST_FULL : (id_pending ? ST_PENDING : ST_OK);
			end else if (req_q.op == OP_REMOVE) begin
				rsp_q.status <= rem_ok ? ST_OK : ST_EMPTY;
			end else begin
				rsp_q.status <= ST_EMPTY;
			end
		end
		if (state_q == S_OUT) begin
			rsp_q <= '0;
			if (hit_q) begin
				rsp_q.status         <= ST_OK;
				rsp_q.found_id       <= 6'(bid_q);
				rsp_q.fired_deadline <= bdl_q;
				if ((req_q.op != OP_PEEK) && brearm_q) begin
					rsp_q.rearmed       <= 1'b1;
					rsp_q.next_deadline <= nxt_q;
				end
			end else begin
				rsp_q.status <= ST_EMPTY;
			end
		end
	end

	assign busy = (state_q != S_IDLE);
	assign done = done_q;
	assign rsp  = rsp_q;

endmodule

### rtl/core/ptsch_cell.sv
// ----------------------------------------------------------------------------
// Timer cell
// Holds one timer slot and compares it against the candidate passed along.
// ----------------------------------------------------------------------------
module ptsch_cell import ptsch_pkg::*; #(
	parameter int IW    = 6,
	parameter int SW    = 32,
	parameter int INDEX = 0
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  cell_ctl_t              ctl,
	input  logic                   wr_clock,
	input  logic [TIME_BITS-1:0]   wr_deadline,
	input  logic [PERIOD_BITS-1:0] wr_period,
	input  logic [SW-1:0]          wr_seq,
	input  logic                   sel_clock,
	input  logic                   in_valid,
	input  logic [IW-1:0]          in_id,
	input  logic [TIME_BITS-1:0]   in_deadline,
	input  logic [PERIOD_BITS-1:0] in_period,
	input  logic [SW-1:0]          in_seq,
	output logic                   out_valid,
	output logic [IW-1:0]          out_id,
	output logic [TIME_BITS-1:0]   out_deadline,
	output logic [PERIOD_BITS-1:0] out_period,
	output logic [SW-1:0]          out_seq,
	output logic                   pending,
	output logic                   clock_of
);

	logic                   pending_q;
	logic                   clock_q;
	logic [TIME_BITS-1:0]   deadline_q;
	logic [PERIOD_BITS-1:0] period_q;
	logic [SW-1:0]          seq_q;
	logic                   valid_q;
	logic [IW-1:0]          id_q;
	logic [TIME_BITS-1:0]   cdl_q;
	logic [PERIOD_BITS-1:0] cper_q;
	logic [SW-1:0]          cseq_q;
	logic                   take;

	assign take = pending_q && (clock_q == sel_clock) && (!in_valid ||
		(deadline_q < in_deadline) || ((deadline_q == in_deadline) && (seq_q < in_seq)));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q <= 1'b0;
			valid_q   <= 1'b0;
		end else begin
			if (ctl.add_we) begin
				pending_q <= 1'b1;
			end else if (ctl.clr) begin
				pending_q <= 1'b0;
			end
			if (ctl.scan_en) begin
				valid_q <= in_valid || take;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.add_we) begin
			clock_q    <= wr_clock;
			deadline_q <= wr_deadline;
			period_q   <= wr_period;
			seq_q      <= wr_seq;
		end else if (ctl.rearm) begin
			deadline_q <= wr_deadline;
			seq_q      <= wr_seq;
		end
		if (ctl.scan_en) begin
			if (take) begin
				id_q   <= IW'(INDEX);
				cdl_q  <= deadline_q;
				cper_q <= period_q;
				cseq_q <= seq_q;
			end else begin
				id_q   <= in_id;
				cdl_q  <= in_deadline;
				cper_q <= in_period;
				cseq_q <= in_seq;
			end
		end
	end

	assign out_valid    = valid_q;
	assign out_id       = id_q;
	assign out_deadline = cdl_q;
	assign out_period   = cper_q;
	assign out_seq      = cseq_q;
	assign pending      = pending_q;
	assign clock_of     = clock_q;

endmodule
